>>> rtl/series_smoothing_filter_assert.svh
// Assertion macros for the series smoothing filter.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef SERIES_SMOOTHING_FILTER_ASSERT_SVH
`define SERIES_SMOOTHING_FILTER_ASSERT_SVH

// cons must hold in the same cycle as ante
`define SSF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define SSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ssf_pkg.sv
// Shared constants, register codes and saturation helper for the smoothing filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssf_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int DEF_MAX_WINDOW = 64;
    localparam int WINDOW_W       = 10;
    localparam int ALPHA_W        = 17;
    localparam int DIVISOR_W      = 11;
    localparam int MAC_W          = 33;
    localparam int ACC_W          = 2 * MAC_W;
    localparam int Q_SHIFT        = 16;
    localparam int ALPHA_MAX      = 65536;
    localparam int ALPHA_NUM      = 131072;
    localparam int ADDR_W         = 5;
    localparam int REG_IDX_W      = 3;
    localparam int CFG_W          = 32;

    localparam logic [2:0] MODE_PASS = 3'd0;
    localparam logic [2:0] MODE_SMA  = 3'd1;
    localparam logic [2:0] MODE_EMA  = 3'd2;
    localparam logic [2:0] MODE_ADD  = 3'd3;
    localparam logic [2:0] MODE_MUL  = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ADD    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FACTOR = 3'd4;

    localparam logic [WINDOW_W-1:0] WINDOW_RST = 10'd3;
    localparam logic [SAMPLE_W-1:0] FACTOR_RST = 32'h0001_0000;

    // clamp a wide signed value into the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-SAMPLE_W:0]     top;
        logic signed [SAMPLE_W-1:0]  r;
        top = v[ACC_W-1:SAMPLE_W-1];
        if ((&top) || !(|top))
            r = v[SAMPLE_W-1:0];
        else if (v[ACC_W-1])
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/series_smoothing_filter.sv
// Series smoothing filter top level: register port, sequencer, history RAM,
// shared divider and shared multiply-accumulate. Depends on ssf_pkg, ssf_ram,
// ssf_div, ssf_mac and series_smoothing_filter_assert.svh.
//
//  channel  | direction | handshake              | payload
//  s_       | in        | s_tvalid / s_tready    | s_tdata = sample, s_tlast = series_end
//  m_       | out       | m_tvalid / m_tready    | m_tdata = value,  m_tlast = last
//  apb      | in        | psel & penable & pwrite| paddr, pwdata, prdata (pready tied high)
//
// One request at a time; s_tready is high only while the sequencer is idle.
// Passthrough/add go straight to the output push; multiply passes MUL_A and PROD;
// later EMA samples pass EMA_A, EMA_B and EMA_F, after the divider when alpha is
// derived from the window. SMA steady state waits on the 2-bit-per-cycle divider.
// Window fill emits one copy per cycle while the output is not stalled; short-series
// replay reads held samples via the registered RAM. Output stalls hold the sequencer.
// Reset is asynchronous; history RAM is not cleared (never read before written).
`timescale 1ns / 1ps
`default_nettype none
`include "series_smoothing_filter_assert.svh"

module series_smoothing_filter #(
    parameter int MAX_WINDOW = ssf_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ssf_pkg::SAMPLE_W-1:0]  s_tdata,   // [31:0] sample
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [ssf_pkg::SAMPLE_W-1:0]  m_tdata,   // [31:0] value
    output logic                               m_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ssf_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [ssf_pkg::CFG_W-1:0]     pwdata,
    output logic      [ssf_pkg::CFG_W-1:0]     prdata,
    output logic                               pready
);
    import ssf_pkg::*;

    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam logic [CW-1:0] MAXW_C = CW'(MAX_WINDOW);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_MUL_A,
        ST_PROD,
        ST_EMA_A,
        ST_EMA_B,
        ST_EMA_F,
        ST_RING_UPD,
        ST_DIV_START,
        ST_DIV,
        ST_FILL,
        ST_REPLAY_RD,
        ST_REPLAY_WT
    } state_t;

    state_t                     state_reg, state_next;
    logic [2:0]                 mode_reg, mode_next;
    logic [WINDOW_W-1:0]        window_reg, window_next;
    logic [ALPHA_W-1:0]         alpha_reg, alpha_next;
    logic signed [SAMPLE_W-1:0] add_reg, add_next;
    logic signed [SAMPLE_W-1:0] factor_reg, factor_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [CW-1:0]              seen_reg, seen_next;
    logic [AW-1:0]              ring_reg, ring_next;
    logic signed [SAMPLE_W-1:0] smoothed_reg, smoothed_next;
    logic                       first_reg, first_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic                       end_reg, end_next;
    logic [SAMPLE_W-1:0]        res_reg, res_next;
    logic [ALPHA_W-1:0]         a_reg, a_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       fill_reg, fill_next;
    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]        out_value_reg, out_value_next;
    logic                       out_last_reg, out_last_next;

    // datapath unit hookups
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [SAMPLE_W-1:0]        ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic                       mac_en, mac_clear;
    logic signed [MAC_W-1:0]    mac_a, mac_b;
    logic signed [ACC_W-1:0]    mac_acc;
    logic signed [ACC_W-1:0]    acc_q;
    logic                       div_start, div_done;
    logic signed [SUM_W-1:0]    div_dividend, div_quo;
    logic [DIVISOR_W-1:0]       div_divisor;

    logic signed [SAMPLE_W-1:0] s_x;
    logic [CW-1:0]              w_eff;
    logic [WINDOW_W-1:0]        w_ema;
    logic                       accept;
    logic                       slot_free;
    logic                       cfg_wr;
    logic [REG_IDX_W-1:0]       cfg_idx;
    logic [CW-1:0]              seen_inc;
    logic [CW-1:0]              cnt_inc;
    logic [CW-1:0]              ring_inc;
    logic                       alpha_ok;

    assign s_x       = s_tdata;
    assign w_eff     = (window_reg > WINDOW_W'(MAX_WINDOW)) ? MAXW_C : CW'(window_reg);
    assign w_ema     = (window_reg == '0) ? WINDOW_W'(1) : window_reg;
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_idx   = paddr[ADDR_W-1:2];
    assign seen_inc  = seen_reg + 1'b1;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign ring_inc  = CW'(ring_reg) + 1'b1;
    assign alpha_ok  = (alpha_reg != '0) && (alpha_reg <= ALPHA_W'(ALPHA_MAX));
    assign acc_q     = mac_acc >>> Q_SHIFT;

    // RAM read address follows the replay index during replay, else the ring slot
    assign ram_raddr = ((state_reg == ST_REPLAY_RD) || (state_reg == ST_REPLAY_WT))
                       ? cnt_reg[AW-1:0] : ring_reg;

    always_comb
    begin
        logic finish;
        state_next     = state_reg;
        mode_next      = mode_reg;
        window_next    = window_reg;
        alpha_next     = alpha_reg;
        add_next       = add_reg;
        factor_next    = factor_reg;
        sum_next       = sum_reg;
        seen_next      = seen_reg;
        ring_next      = ring_reg;
        smoothed_next  = smoothed_reg;
        first_next     = first_reg;
        x_next         = x_reg;
        end_next       = end_reg;
        res_next       = res_reg;
        a_next         = a_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = ring_reg;
        ram_wdata      = x_reg;
        mac_en         = 1'b0;
        mac_clear      = 1'b0;
        mac_a          = MAC_W'(x_reg);
        mac_b          = MAC_W'(factor_reg);
        div_start      = 1'b0;
        div_dividend   = sum_reg;
        div_divisor    = DIVISOR_W'(w_eff);
        finish         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next   = s_x;
                    end_next = s_tlast;
                    case (mode_reg)
                        MODE_SMA:
                        begin
                            if (w_eff == '0)
                            begin
                                res_next   = s_x;
                                state_next = ST_PUSH;
                            end
                            else if (seen_reg < w_eff)
                            begin
                                // window still filling: hold the raw sample
                                ram_we    = 1'b1;
                                ram_waddr = seen_reg[AW-1:0];
                                ram_wdata = s_x;
                                sum_next  = sum_reg + SUM_W'(s_x);
                                seen_next = seen_inc;
                                ring_next = (seen_inc == w_eff) ? '0 : seen_inc[AW-1:0];
                                if (seen_inc == w_eff)
                                begin
                                    fill_next  = 1'b1;
                                    state_next = ST_DIV_START;
                                end
                                else if (s_tlast)
                                begin
                                    cnt_next   = '0;
                                    state_next = ST_REPLAY_RD;
                                end
                            end
                            else
                            begin
                                // old sample at ring slot arrives next cycle
                                state_next = ST_RING_UPD;
                            end
                        end
                        MODE_EMA:
                        begin
                            if (first_reg)
                            begin
                                smoothed_next = s_x;
                                first_next    = 1'b0;
                                res_next      = s_x;
                                state_next    = ST_PUSH;
                            end
                            else if (alpha_ok)
                            begin
                                a_next     = alpha_reg;
                                state_next = ST_EMA_A;
                            end
                            else
                            begin
                                state_next = ST_DIV_START;
                            end
                        end
                        MODE_ADD:
                        begin
                            res_next   = sat_sample(ACC_W'(s_x) + ACC_W'(add_reg));
                            state_next = ST_PUSH;
                        end
                        MODE_MUL:
                        begin
                            state_next = ST_MUL_A;
                        end
                        default:
                        begin
                            res_next   = s_x;
                            state_next = ST_PUSH;
                        end
                    endcase
                end
            end
            ST_PUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_last_next  = end_reg;
                    finish         = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_MUL_A:
            begin
                mac_en     = 1'b1;
                mac_clear  = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                res_next   = sat_sample(acc_q);
                state_next = ST_PUSH;
            end
            ST_EMA_A:
            begin
                mac_en     = 1'b1;
                mac_clear  = 1'b1;
                mac_a      = MAC_W'({1'b0, a_reg});
                mac_b      = MAC_W'(x_reg);
                state_next = ST_EMA_B;
            end
            ST_EMA_B:
            begin
                mac_en     = 1'b1;
                mac_a      = MAC_W'({1'b0, ALPHA_W'(ALPHA_MAX) - a_reg});
                mac_b      = MAC_W'(smoothed_reg);
                state_next = ST_EMA_F;
            end
            ST_EMA_F:
            begin
                smoothed_next = acc_q[SAMPLE_W-1:0];
                res_next      = acc_q[SAMPLE_W-1:0];
                state_next    = ST_PUSH;
            end
            ST_RING_UPD:
            begin
                sum_next   = sum_reg + SUM_W'(x_reg) - SUM_W'($signed(ram_rdata));
                ram_we     = 1'b1;
                ram_waddr  = ring_reg;
                ram_wdata  = x_reg;
                ring_next  = (ring_inc == w_eff) ? '0 : ring_inc[AW-1:0];
                fill_next  = 1'b0;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                div_start = 1'b1;
                if (mode_reg == MODE_EMA)
                begin
                    div_dividend = SUM_W'(ALPHA_NUM);
                    div_divisor  = DIVISOR_W'(w_ema) + 1'b1;
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (mode_reg == MODE_EMA)
                    begin
                        a_next     = div_quo[ALPHA_W-1:0];
                        state_next = ST_EMA_A;
                    end
                    else if (fill_reg)
                    begin
                        res_next   = div_quo[SAMPLE_W-1:0];
                        cnt_next   = '0;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        res_next   = div_quo[SAMPLE_W-1:0];
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_FILL:
            begin
                // first full window: one copy of the average per held sample
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_last_next  = end_reg && (cnt_inc == w_eff);
                    cnt_next       = cnt_inc;
                    if (cnt_inc == w_eff)
                    begin
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REPLAY_RD:
            begin
                state_next = ST_REPLAY_WT;
            end
            ST_REPLAY_WT:
            begin
                // short series: raw samples back out in arrival order
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = ram_rdata;
                    out_last_next  = (cnt_inc == seen_reg);
                    if (cnt_inc == seen_reg)
                    begin
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_inc;
                        state_next = ST_REPLAY_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish && end_reg)
        begin
            sum_next   = '0;
            seen_next  = '0;
            ring_next  = '0;
            first_next = 1'b1;
        end

        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MODE:
                begin
                    mode_next  = pwdata[2:0];
                    sum_next   = '0;
                    seen_next  = '0;
                    ring_next  = '0;
                    first_next = 1'b1;
                end
                REG_WINDOW:
                begin
                    window_next = pwdata[WINDOW_W-1:0];
                    sum_next    = '0;
                    seen_next   = '0;
                    ring_next   = '0;
                    first_next  = 1'b1;
                end
                REG_ALPHA:  alpha_next  = pwdata[ALPHA_W-1:0];
                REG_ADD:    add_next    = pwdata;
                REG_FACTOR: factor_next = pwdata;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_PASS;
            window_reg    <= WINDOW_RST;
            alpha_reg     <= '0;
            add_reg       <= '0;
            factor_reg    <= FACTOR_RST;
            sum_reg       <= '0;
            seen_reg      <= '0;
            ring_reg      <= '0;
            smoothed_reg  <= '0;
            first_reg     <= 1'b1;
            fill_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            window_reg    <= window_next;
            alpha_reg     <= alpha_next;
            add_reg       <= add_next;
            factor_reg    <= factor_next;
            sum_reg       <= sum_next;
            seen_reg      <= seen_next;
            ring_reg      <= ring_next;
            smoothed_reg  <= smoothed_next;
            first_reg     <= first_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        end_reg       <= end_next;
        res_reg       <= res_next;
        a_reg         <= a_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    ssf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ssf_div #(
        .DW (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    ssf_mac u_mac (
        .clk   (clk),
        .en    (mac_en),
        .clear (mac_clear),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc)
    );

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_MODE:   prdata = CFG_W'(mode_reg);
            REG_WINDOW: prdata = CFG_W'(window_reg);
            REG_ALPHA:  prdata = CFG_W'(alpha_reg);
            REG_ADD:    prdata = add_reg;
            REG_FACTOR: prdata = factor_reg;
            default:    prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_last_reg;

    `SSF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast),
        "result request changed while stalled")
    `SSF_ASSERT_SAME(a_div_done_in_wait, div_done, state_reg == ST_DIV,
        "divider finished outside the wait state")
    `SSF_ASSERT_SAME(a_seen_in_window, 1'b1, seen_reg <= w_eff,
        "held sample count exceeds the window")

endmodule

`default_nettype wire

>>> rtl/ssf_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ssf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/ssf_div.sv
// Iterative signed-by-unsigned divider, two quotient bits per cycle, truncating.
// Depends on ssf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssf_div #(
    parameter int DW = 38
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [DW-1:0]               dividend,
    input  wire logic        [ssf_pkg::DIVISOR_W-1:0] divisor,
    output logic                                    done,
    output logic signed      [DW-1:0]               quotient
);
    import ssf_pkg::*;

    localparam int EW    = DW + (DW % 2);
    localparam int STEPS = EW / 2;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [EW-1:0]        num_reg, num_next;
    logic [EW-1:0]        quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] den_reg, den_next;
    logic [DW-1:0]        mag;
    logic [DW-1:0]        quo_signed;

    assign mag = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);

    always_comb
    begin
        logic [DIVISOR_W:0]   t;
        logic [DIVISOR_W-1:0] r;
        logic [EW-1:0]        n;
        logic [EW-1:0]        q;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        r = rem_reg;
        n = num_reg;
        q = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            t = {r, n[EW-1]};
            n = {n[EW-2:0], 1'b0};
            if (t >= {1'b0, den_reg})
            begin
                r = DIVISOR_W'(t - {1'b0, den_reg});
                q = {q[EW-2:0], 1'b1};
            end
            else
            begin
                r = t[DIVISOR_W-1:0];
                q = {q[EW-2:0], 1'b0};
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[DW-1];
            num_next  = EW'(mag);
            quo_next  = '0;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            num_next = n;
            quo_next = q;
            rem_next = r;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo_signed = neg_reg ? DW'(-quo_reg[DW-1:0]) : quo_reg[DW-1:0];
    assign quotient   = quo_signed;
    assign done       = done_reg;

endmodule

`default_nettype wire

>>> rtl/ssf_mac.sv
// Shared signed multiply-accumulate unit with a registered result.
// Depends on ssf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssf_mac (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic                               clear,
    input  wire logic signed [ssf_pkg::MAC_W-1:0]   a,
    input  wire logic signed [ssf_pkg::MAC_W-1:0]   b,
    output logic signed      [ssf_pkg::ACC_W-1:0]   acc
);
    import ssf_pkg::*;

    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    assign prod     = a * b;
    assign acc_next = clear ? prod : ACC_W'(acc_reg + prod);

    always_ff @(posedge clk)
    begin
        if (en)
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

>>> dv/tb_series_smoothing_filter.sv
// Self-checking testbench for series_smoothing_filter: directed and random sample
// series through every mode, with random idling on both streams and register writes.
// Depends on ssf_pkg and the series_smoothing_filter RTL.
`timescale 1ns / 1ps

// Holds the filter state mirror and the queue of expected values.
class smoothing_scoreboard;
    logic [2:0]         mode_q;
    logic [9:0]         window_q;
    logic [16:0]        alpha_q;
    logic signed [31:0] add_q;
    logic signed [31:0] factor_q;
    logic signed [31:0] held [64];
    logic signed [37:0] sum_q;
    int                 count_q;
    int                 ptr_q;
    logic signed [31:0] ema_q;
    bit                 fresh_q;
    logic [32:0]        pending [$];
    int                 errors;

    function new();
        mode_q = ssf_pkg::MODE_PASS;
        window_q = 10'd3;
        alpha_q = '0;
        add_q = '0;
        factor_q = 32'sh0001_0000;
        ema_q = '0;
        errors = 0;
        restart();
    endfunction

    function void restart();
        sum_q = '0;
        count_q = 0;
        ptr_q = 0;
        fresh_q = 1'b1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            ssf_pkg::REG_MODE:   begin mode_q = val[2:0]; restart(); end
            ssf_pkg::REG_WINDOW: begin window_q = val[9:0]; restart(); end
            ssf_pkg::REG_ALPHA:  alpha_q = val[16:0];
            ssf_pkg::REG_ADD:    add_q = val;
            ssf_pkg::REG_FACTOR: factor_q = val;
            default: ;
        endcase
    endfunction

    function logic signed [31:0] clamp(logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -66'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function void push(logic signed [31:0] v, bit l);
        pending.push_back({l, v});
    endfunction

    // notes an accepted sample and queues the values it causes
    function void note_sample(logic signed [31:0] x, bit fin);
        int                 w;
        longint             a;
        logic signed [65:0] p;
        logic signed [31:0] avg;
        case (mode_q)
            ssf_pkg::MODE_SMA:
            begin
                w = (window_q > 64) ? 64 : window_q;
                if (w == 0)
                    push(x, fin);
                else if (count_q < w)
                begin
                    held[count_q] = x;
                    sum_q += x;
                    count_q++;
                    ptr_q = count_q % w;
                    if (count_q == w)
                    begin
                        avg = sum_q / w;
                        for (int i = 0; i < w; i++)
                            push(avg, fin && (i == w - 1));
                    end
                    else if (fin)
                        for (int i = 0; i < count_q; i++)
                            push(held[i], i == count_q - 1);
                end
                else
                begin
                    sum_q += x - held[ptr_q];
                    held[ptr_q] = x;
                    ptr_q = (ptr_q + 1) % w;
                    push(sum_q / w, fin);
                end
            end
            ssf_pkg::MODE_EMA:
            begin
                a = alpha_q;
                if (a == 0 || a > 65536)
                    a = 131072 / (((window_q < 1) ? 1 : window_q) + 1);
                if (fresh_q)
                begin
                    ema_q = x;
                    fresh_q = 1'b0;
                end
                else
                begin
                    p = a * x + (65536 - a) * ema_q;
                    ema_q = p >>> 16;
                end
                push(ema_q, fin);
            end
            ssf_pkg::MODE_ADD:
                push(clamp(66'(x) + 66'(add_q)), fin);
            ssf_pkg::MODE_MUL:
            begin
                p = 66'(x) * 66'(factor_q);
                push(clamp(p >>> 16), fin);
            end
            default: push(x, fin);
        endcase
        if (fin)
            restart();
    endfunction

    function void check_result(logic [31:0] v, bit l);
        logic [32:0] e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result value=%h last=%b", $realtime, v, l);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e[31:0] !== v)
        begin
            $display("%0t: value expected %h actual %h", $realtime, e[31:0], v);
            errors++;
        end
        if (e[32] !== l)
        begin
            $display("%0t: last expected %b actual %b", $realtime, e[32], l);
            errors++;
        end
    endfunction
endclass

module tb_series_smoothing_filter;
    import ssf_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata = '0;   // [31:0] sample
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;        // [31:0] value
    logic                m_tlast;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [CFG_W-1:0]    pwdata = '0;
    logic [CFG_W-1:0]    prdata;
    logic                pready;

    smoothing_scoreboard sb = new();
    int  send_idle = 0;   // percent of cycles the sender holds off
    int  recv_stall = 0;  // percent of cycles the receiver stalls
    int  quiet = 0;       // cycles with no accepted request

    localparam int WATCHDOG = 20000;

    always #1 clk = ~clk;

    series_smoothing_filter u_dut (.*);

    // receiver: random stall, results checked at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog on cycles with no request moving on either stream
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG)
        begin
            $display("series_smoothing_filter verification failed");
            $finish;
        end
    end

    // tvalid stays up after an accept until the next request or an idle cycle
    task automatic send(logic [31:0] x, bit fin);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        s_tlast <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(x, fin);
    endtask

    // register writes only while idle: drain, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    // one series of len samples, end mark on the last unless broken
    task automatic series(int len, bit mark);
        for (int i = 0; i < len; i++)
            send(rand_sample(), mark && (i == len - 1));
    endtask

    task automatic random_phase(int n);
        int done;
        int len;
        done = 0;
        while (done < n)
        begin
            len = $urandom_range(12, 1);
            series(len, $urandom_range(9) != 0);
            done += len;
        end
    endtask

    initial
    begin
        logic [2:0] m;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: passthrough extremes, SMA fill, short series, window zero
        send(32'h7fff_ffff, 1'b0);
        send(32'h8000_0000, 1'b1);
        write_reg(REG_MODE, MODE_SMA);
        series(3, 1'b1);
        series(5, 1'b1);
        series(2, 1'b1);   // ends before the window fills
        write_reg(REG_WINDOW, 0);
        series(2, 1'b1);
        write_reg(REG_WINDOW, 1000);   // saturates to the maximum window
        series(3, 1'b1);
        write_reg(REG_MODE, MODE_EMA);
        send(32'h0001_0000, 1'b0);
        send(32'hffff_0000, 1'b1);
        write_reg(REG_ALPHA, 65536);
        series(2, 1'b1);
        write_reg(REG_MODE, MODE_ADD);
        write_reg(REG_ADD, 32'h7fff_ffff);
        send(32'h0000_0001, 1'b1);     // positive saturation
        write_reg(REG_ADD, 32'h8000_0000);
        send(32'h8000_0000, 1'b1);     // negative saturation
        write_reg(REG_MODE, MODE_MUL);
        write_reg(REG_FACTOR, 32'h8000_0000);
        send(32'h8000_0000, 1'b1);
        send(32'h7fff_ffff, 1'b1);
        write_reg(REG_MODE, 3'd7);     // unused code acts as passthrough
        send(32'h1234_5678, 1'b1);

        // random phases over idling profiles and register settings
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 82; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 82; end
                default: begin send_idle = 35; recv_stall = 35; end
            endcase
            m = $urandom_range(5);
            write_reg(REG_WINDOW, (ph % 3 == 0) ? $urandom_range(8) : $urandom_range(1023));
            write_reg(REG_ALPHA, (ph % 2) ? 0 : $urandom_range(131071));
            write_reg(REG_ADD, $urandom);
            write_reg(REG_FACTOR, $urandom);
            write_reg(REG_MODE, m);
            random_phase(6);
            drain();       // sender waits for every expected result
            random_phase(6);
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("series_smoothing_filter verification clean");
        else
            $display("series_smoothing_filter verification failed");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/ssf_pkg.sv
rtl/ssf_ram.sv
rtl/ssf_div.sv
rtl/ssf_mac.sv
rtl/series_smoothing_filter.sv
dv/tb_series_smoothing_filter.sv
